// ===== rtl/core/pdbt_pkg.sv =====
// shared types, constants and helpers for the pulse-distance byte transmitter
`default_nettype none

package pdbt_pkg;

    localparam int PDBT_DATA_BITS = 8;
    localparam int CFG_W          = 10;
    localparam int TICK_W         = 11;
    localparam int CFG_ADDR_W     = 3;
    localparam int BYTE_W         = 8;

    localparam logic [CFG_W-1:0] GAP_LOW_RST    = CFG_W'(100);
    localparam logic [CFG_W-1:0] START_HIGH_RST = CFG_W'(250);
    localparam logic [CFG_W-1:0] ZERO_LOW_RST   = CFG_W'(19);
    localparam logic [CFG_W-1:0] ONE_EXTRA_RST  = CFG_W'(50);
    localparam logic [CFG_W-1:0] MARK_HIGH_RST  = CFG_W'(79);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GAP_LOW    = 3'd0,
        REG_START_HIGH = 3'd1,
        REG_ZERO_LOW   = 3'd2,
        REG_ONE_EXTRA  = 3'd3,
        REG_MARK_HIGH  = 3'd4
    } cfg_addr_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_GAP   = 3'd1,
        PH_START = 3'd2,
        PH_LOW   = 3'd3,
        PH_MARK  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] gap_low_ticks;
        logic [CFG_W-1:0] start_high_ticks;
        logic [CFG_W-1:0] zero_low_ticks;
        logic [CFG_W-1:0] one_extra_ticks;
        logic [CFG_W-1:0] mark_high_ticks;
    } timing_cfg_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic accepted;
        logic frame_done;
    } result_t;

    // a phase of zero length still lasts one tick
    function automatic logic [TICK_W-1:0] phase_len(input logic [TICK_W-1:0] n);
        phase_len = (n == '0) ? TICK_W'(1) : n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pulse_distance_byte_transmitter_top.sv =====
// top level of the pulse-distance byte transmitter
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  s_action, s_data_byte
//  m_       out        m_valid / m_ready  m_line_level, m_busy_res, m_accepted, m_frame_done
//  cfg_     in         cfg_wr_en          cfg_addr, cfg_wdata
//
// one item per cycle while s_ready is high; each item updates the frame state in the cycle it is taken
// and its result appears in the output register on the next cycle
// s_ready stays high while the output register is empty or being drained
// synchronous active-low reset restores the default timings and the idle phase
`default_nettype none

module pulse_distance_byte_transmitter_top
    import pdbt_pkg::*;
#(
    parameter int DATA_BITS = PDBT_DATA_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_action,
    input  wire logic [BYTE_W-1:0]     s_data_byte,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_line_level,
    output logic                       m_busy_res,
    output logic                       m_accepted,
    output logic                       m_frame_done,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);

    timing_cfg_t cfg;
    result_t     res_new;
    result_t     res_out;
    logic        step;

    assign step = s_valid && s_ready;

    pdbt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pdbt_frame_engine #(
        .DATA_BITS (DATA_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .action    (s_action),
        .data_byte (s_data_byte),
        .cfg       (cfg),
        .res       (res_new)
    );

    pdbt_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .res_in   (res_new),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .res_out  (res_out),
        .can_load (s_ready)
    );

    assign m_line_level = res_out.line_level;
    assign m_busy_res   = res_out.busy_res;
    assign m_accepted   = res_out.accepted;
    assign m_frame_done = res_out.frame_done;

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accepted) |-> m_busy_res)
        else $error("accepted load without busy");

    a_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_done) |-> (!m_busy_res && m_line_level && !m_accepted))
        else $error("frame end result inconsistent");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while output free");

    a_item_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("taken item left no result");

endmodule

`default_nettype wire

// ===== rtl/core/pdbt_cfg_regs.sv =====
// timing configuration registers
`default_nettype none

module pdbt_cfg_regs
    import pdbt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    output timing_cfg_t                cfg
);

    timing_cfg_t cfg_reg;
    timing_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr_t'(cfg_addr))
                REG_GAP_LOW:    cfg_next.gap_low_ticks    = cfg_wdata;
                REG_START_HIGH: cfg_next.start_high_ticks = cfg_wdata;
                REG_ZERO_LOW:   cfg_next.zero_low_ticks   = cfg_wdata;
                REG_ONE_EXTRA:  cfg_next.one_extra_ticks  = cfg_wdata;
                REG_MARK_HIGH:  cfg_next.mark_high_ticks  = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gap_low_ticks    <= GAP_LOW_RST;
            cfg_reg.start_high_ticks <= START_HIGH_RST;
            cfg_reg.zero_low_ticks   <= ZERO_LOW_RST;
            cfg_reg.one_extra_ticks  <= ONE_EXTRA_RST;
            cfg_reg.mark_high_ticks  <= MARK_HIGH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pdbt_frame_engine.sv =====
// frame sequencer: phase, tick counter, bit shifter and per-item result
`default_nettype none

module pdbt_frame_engine
    import pdbt_pkg::*;
#(
    parameter int DATA_BITS = PDBT_DATA_BITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic              action,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire timing_cfg_t       cfg,
    output result_t                res
);

    localparam int BITS_W = $clog2(DATA_BITS + 1);
    localparam int LOAD_W = (DATA_BITS < BYTE_W) ? DATA_BITS : BYTE_W;

    phase_t                phase_reg, phase_next;
    logic [TICK_W-1:0]     ticks_reg, ticks_next;
    logic [DATA_BITS-1:0]  shift_reg, shift_next;
    logic [BITS_W-1:0]     bits_reg, bits_next;
    logic                  done;

    logic [DATA_BITS-1:0]  load_val;
    logic [DATA_BITS-1:0]  shift_shl;
    logic [TICK_W-1:0]     low_len_cur;
    logic [TICK_W-1:0]     low_len_shl;

    assign load_val  = DATA_BITS'(data_byte[LOAD_W-1:0]);
    assign shift_shl = shift_reg << 1;

    assign low_len_cur = phase_len(TICK_W'(cfg.zero_low_ticks)
        + (shift_reg[DATA_BITS-1] ? TICK_W'(cfg.one_extra_ticks) : TICK_W'(0)));
    assign low_len_shl = phase_len(TICK_W'(cfg.zero_low_ticks)
        + (shift_shl[DATA_BITS-1] ? TICK_W'(cfg.one_extra_ticks) : TICK_W'(0)));

    // next state
    always_comb begin
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        done       = 1'b0;
        if (step) begin
            if (action) begin
                if (phase_reg == PH_IDLE) begin
                    shift_next = load_val;
                    bits_next  = BITS_W'(DATA_BITS);
                    phase_next = PH_GAP;
                    ticks_next = phase_len(TICK_W'(cfg.gap_low_ticks));
                end
            end else if (phase_reg != PH_IDLE) begin
                if (ticks_reg > TICK_W'(1)) begin
                    ticks_next = ticks_reg - TICK_W'(1);
                end else begin
                    case (phase_reg)
                        PH_GAP: begin
                            phase_next = PH_START;
                            ticks_next = phase_len(TICK_W'(cfg.start_high_ticks));
                        end
                        PH_START: begin
                            phase_next = PH_LOW;
                            ticks_next = low_len_cur;
                        end
                        PH_LOW: begin
                            phase_next = PH_MARK;
                            ticks_next = phase_len(TICK_W'(cfg.mark_high_ticks));
                        end
                        PH_MARK: begin
                            if (bits_reg <= BITS_W'(1)) begin
                                bits_next  = '0;
                                ticks_next = '0;
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end else begin
                                bits_next  = bits_reg - BITS_W'(1);
                                shift_next = shift_shl;
                                phase_next = PH_LOW;
                                ticks_next = low_len_shl;
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    // item result
    always_comb begin
        res.line_level = (phase_next == PH_START || phase_next == PH_MARK);
        if (!action) begin
            res.line_level = (phase_reg == PH_START || phase_reg == PH_MARK);
        end
        res.busy_res   = (phase_next != PH_IDLE);
        res.accepted   = action && (phase_reg == PH_IDLE);
        res.frame_done = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            ticks_reg <= '0;
            shift_reg <= '0;
            bits_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pdbt_out_stage.sv =====
// result register with valid/ready handshake
`default_nettype none

module pdbt_out_stage
    import pdbt_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t res_in,
    input  wire logic    m_ready,
    output logic         m_valid,
    output result_t      res_out,
    output logic         can_load
);

    logic    valid_reg, valid_next;
    result_t res_reg, res_next;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (load) begin
            valid_next = 1'b1;
            res_next   = res_in;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid = valid_reg;
    assign res_out = res_reg;

endmodule

`default_nettype wire
